/* hw/rtl/linear_recurrence_term_mod_defines.svh */
// ---------------------------------------------------------------------------
// linear_recurrence_term_mod assertion macros
// Shared concurrent-assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LINEAR_RECURRENCE_TERM_MOD_DEFINES_SVH
`define LINEAR_RECURRENCE_TERM_MOD_DEFINES_SVH

// Same-cycle implication.
`define LRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lrt_pkg.sv */
// ---------------------------------------------------------------------------
// lrt_pkg
// Command codes, register indexes and sequencer states of the recurrence block.
// ---------------------------------------------------------------------------
package lrt_pkg;

  localparam logic [1:0] CMD_TAP   = 2'd0;
  localparam logic [1:0] CMD_SEED  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_ORDER   = 1'b1;

  localparam int CMD_BITS  = 2;
  localparam int SLOT_BITS = 3;
  localparam int ORD_BITS  = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_RUN,
    ST_INIT,
    ST_INIT_RUN,
    ST_CHECK,
    ST_MM_RD,
    ST_MM_MUL,
    ST_MM_RUN,
    ST_CP_RD,
    ST_CP_WR,
    ST_FIN_RD,
    ST_FIN_MUL,
    ST_FIN_RUN,
    ST_OUT
  } state_t;

endpackage

/* hw/rtl/lrt_ram.sv */
// ---------------------------------------------------------------------------
// lrt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module lrt_ram #(
  parameter int DW = 31,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lrt_mulmod.sv */
// ---------------------------------------------------------------------------
// lrt_mulmod
// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
// ---------------------------------------------------------------------------
module lrt_mulmod #(
  parameter int VB = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [VB-1:0] a,      // must be below m
  input  logic [VB-1:0] b,
  input  logic [VB-1:0] m,
  output logic          done,
  output logic [VB-1:0] res
);

  localparam int CW = $clog2(VB + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VB-1:0] r_r, r_nxt;
  logic [VB-1:0] a_r, a_nxt;
  logic [VB-1:0] b_r, b_nxt;
  logic [VB+1:0] sum, m1, m2, step;

  // r = 2r + bit*a, below 3m; pick one of three candidates
  always_comb begin
    sum  = {1'b0, r_r, 1'b0} + (b_r[VB-1] ? {2'b00, a_r} : '0);
    m1   = {2'b00, m};
    m2   = {1'b0, m, 1'b0};
    if (sum >= m2) begin
      step = sum - m2;
    end else if (sum >= m1) begin
      step = sum - m1;
    end else begin
      step = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    r_nxt    = r_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(VB);
      r_nxt    = '0;
      a_nxt    = a;
      b_nxt    = b;
    end else if (busy_r) begin
      r_nxt   = step[VB-1:0];
      b_nxt   = {b_r[VB-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    r_r <= r_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign res  = r_r;

endmodule

/* hw/rtl/linear_recurrence_term_mod.sv */
// ---------------------------------------------------------------------------
// linear_recurrence_term_mod
// Term k of an order-n linear recurrence mod m by companion-matrix powering.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_addr/cfg_data write the modulus (index 0) and the order
//   (index 1); write them only while the block is idle.
//   The in_ stream carries commands in in_tuser: write tap, write seed (both
//   reduced mod m, no result) or start (term index in exponent, one result).
//   The out_ stream returns term k in out_tdata.
// Operation:
//   Every modular product runs through one bit-serial multiplier, one bit
//   per cycle. One item is worked on at a time; in_tready is high only
//   between items.
// Reset: synchronous, active low; taps and seeds clear to zero, the
//   modulus to 2 and the order to 1. Matrix RAMs need no clearing.
// Stall: a finished result waits in the output register while the next
//   item is already taken; a second result then holds until it drains.
// ---------------------------------------------------------------------------
`include "linear_recurrence_term_mod_defines.svh"

module linear_recurrence_term_mod
  import lrt_pkg::*;
#(
  parameter int MAX_ORDER  = 8,
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // from bit 0: slot, value, exponent
  input  logic [((SLOT_BITS+2*VALUE_BITS+7)/8)*8-1:0] in_tdata,
  // from bit 0: command
  input  logic [CMD_BITS-1:0]   in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // term from bit 0
  output logic [((VALUE_BITS+7)/8)*8-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [VALUE_BITS-1:0] cfg_data
);

  localparam int VB    = VALUE_BITS;
  localparam int OUT_W = ((VB + 7) / 8) * 8;
  localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int AW    = 2 * IW;
  localparam int SW    = (IW > SLOT_BITS) ? IW : SLOT_BITS;
  localparam logic [5:0] MAXO = 6'(MAX_ORDER);

  // input fields
  logic [CMD_BITS-1:0]  in_cmd;
  logic [SLOT_BITS-1:0] in_slot;
  logic [VB-1:0]        in_value;
  logic [VB-1:0]        in_exp;
  logic [SW-1:0]        slot_ext;
  logic                 slot_ok;
  logic                 in_xfer;

  assign in_cmd   = in_tuser;
  assign in_slot  = in_tdata[SLOT_BITS-1:0];
  assign in_value = in_tdata[SLOT_BITS +: VB];
  assign in_exp   = in_tdata[SLOT_BITS+VB +: VB];
  assign slot_ext = SW'(in_slot);
  assign slot_ok  = ({3'b000, in_slot} < MAXO);
  assign in_xfer  = in_tvalid & in_tready;

  // configuration
  logic [VB-1:0]       modulus_r;
  logic [ORD_BITS-1:0] order_r;
  logic                small_mod;
  logic [5:0]          nl_w;
  logic [IW-1:0]       nl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= VB'(2);
      order_r   <= ORD_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MODULUS: modulus_r <= cfg_data;
        CFG_ORDER:   order_r   <= cfg_data[ORD_BITS-1:0];
        default:     modulus_r <= modulus_r;
      endcase
    end
  end

  // clamp order to 1..MAX_ORDER; nl is the last index in use
  always_comb begin
    if (order_r == '0) begin
      nl_w = 6'd0;
    end else if ({2'b00, order_r} > MAXO) begin
      nl_w = MAXO - 6'd1;
    end else begin
      nl_w = {2'b00, order_r} - 6'd1;
    end
  end
  assign nl        = nl_w[IW-1:0];
  assign small_mod = (modulus_r < VB'(2));

  // sequencer registers
  state_t        state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, z_r, z_nxt;
  logic [VB-1:0] acc_r, acc_nxt;
  logic [VB-1:0] res_r, res_nxt;
  logic [VB-1:0] e_r, e_nxt;
  logic          pdone_r, pdone_nxt;
  logic          sq_r, sq_nxt;
  logic          seed_sel_r, seed_sel_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [VB-1:0] out_term_r, out_term_nxt;

  logic [VB-1:0] tap_r  [MAX_ORDER];
  logic [VB-1:0] seed_r [MAX_ORDER];

  // multiplier
  logic          mul_start, mul_done;
  logic [VB-1:0] mul_a, mul_b, mul_res;

  lrt_mulmod #(.VB(VB)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (modulus_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  // matrix RAMs: P power, S scratch (two copies for two read ports), T temp
  logic          p_we, s_we, t_we;
  logic [AW-1:0] p_waddr, s_waddr, t_waddr;
  logic [VB-1:0] p_wdata, s_wdata, t_wdata;
  logic [AW-1:0] p_raddr, sa_raddr, sb_raddr, t_raddr;
  logic [VB-1:0] p_q, sa_q, sb_q, t_q;

  lrt_ram #(.DW(VB), .AW(AW)) u_pram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_q)
  );
  lrt_ram #(.DW(VB), .AW(AW)) u_sram_a (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(sa_raddr), .rdata(sa_q)
  );
  lrt_ram #(.DW(VB), .AW(AW)) u_sram_b (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(sb_raddr), .rdata(sb_q)
  );
  lrt_ram #(.DW(VB), .AW(AW)) u_tram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_q)
  );

  // helpers
  logic          last_i, last_j, last_z, diag, superdiag;
  logic [VB:0]   acc_sum_w;
  logic [VB-1:0] acc_sum;
  logic [VB-1:0] e_shift;
  logic          out_busy;

  assign last_i    = (i_r == nl);
  assign last_j    = (j_r == nl);
  assign last_z    = (z_r == nl);
  assign diag      = (i_r == j_r);
  assign superdiag = (({1'b0, i_r} + 1'b1) == {1'b0, j_r});
  assign acc_sum_w = {1'b0, acc_r} + {1'b0, mul_res};
  assign acc_sum   = (acc_sum_w >= {1'b0, modulus_r}) ?
                     VB'(acc_sum_w - {1'b0, modulus_r}) : acc_sum_w[VB-1:0];
  assign e_shift   = e_r >> 1;
  assign out_busy  = out_valid_r & ~out_tready;

  // read addresses follow the counters
  assign p_raddr  = ((state_r == ST_FIN_RD) || (state_r == ST_FIN_MUL)) ?
                    {{IW{1'b0}}, j_r} : {i_r, z_r};
  assign sa_raddr = {i_r, z_r};
  assign sb_raddr = {z_r, j_r};
  assign t_raddr  = {i_r, j_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((in_cmd == CMD_TAP || in_cmd == CMD_SEED) && slot_ok && !small_mod) begin
            state_nxt = ST_LOAD_RUN;
          end else if (in_cmd == CMD_START) begin
            state_nxt = small_mod ? ST_OUT : ST_INIT;
          end
        end
      end
      ST_LOAD_RUN: if (mul_done) state_nxt = ST_IDLE;
      ST_INIT: begin
        if (last_i) begin
          state_nxt = ST_INIT_RUN;
        end
      end
      ST_INIT_RUN: begin
        if (mul_done) begin
          state_nxt = last_j ? ST_CHECK : ST_INIT;
        end
      end
      ST_CHECK: begin
        if (e_r == '0) begin
          state_nxt = ST_FIN_RD;
        end else if (e_r[0] && !pdone_r) begin
          state_nxt = ST_MM_RD;
        end else begin
          state_nxt = (e_shift != '0) ? ST_MM_RD : ST_FIN_RD;
        end
      end
      ST_MM_RD:  state_nxt = ST_MM_MUL;
      ST_MM_MUL: state_nxt = ST_MM_RUN;
      ST_MM_RUN: begin
        if (mul_done) begin
          state_nxt = (last_z && last_i && last_j) ? ST_CP_RD : ST_MM_RD;
        end
      end
      ST_CP_RD: state_nxt = ST_CP_WR;
      ST_CP_WR: state_nxt = (last_i && last_j) ? ST_CHECK : ST_CP_RD;
      ST_FIN_RD:  state_nxt = ST_FIN_MUL;
      ST_FIN_MUL: state_nxt = ST_FIN_RUN;
      ST_FIN_RUN: begin
        if (mul_done) begin
          state_nxt = last_j ? ST_OUT : ST_FIN_RD;
        end
      end
      ST_OUT: if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and strobes
  logic          st_we, st_seed;
  logic [IW-1:0] st_idx;
  logic [VB-1:0] st_wdata;

  always_comb begin
    i_nxt         = i_r;
    j_nxt         = j_r;
    z_nxt         = z_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    e_nxt         = e_r;
    pdone_nxt     = pdone_r;
    sq_nxt        = sq_r;
    seed_sel_nxt  = seed_sel_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_busy;
    out_term_nxt  = out_term_r;
    mul_start     = 1'b0;
    mul_a         = VB'(1);
    mul_b         = in_value;
    p_we          = 1'b0;
    s_we          = 1'b0;
    t_we          = 1'b0;
    p_waddr       = {i_r, j_r};
    s_waddr       = {i_r, j_r};
    t_waddr       = {i_r, j_r};
    p_wdata       = diag ? VB'(1) : '0;
    s_wdata       = superdiag ? VB'(1) : '0;
    t_wdata       = acc_sum;
    st_we         = 1'b0;
    st_seed       = seed_sel_r;
    st_idx        = slot_r;
    st_wdata      = mul_res;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((in_cmd == CMD_TAP || in_cmd == CMD_SEED) && slot_ok) begin
            seed_sel_nxt = (in_cmd == CMD_SEED);
            slot_nxt     = slot_ext[IW-1:0];
            if (small_mod) begin
              // a modulus below two stores zero
              st_we    = 1'b1;
              st_seed  = (in_cmd == CMD_SEED);
              st_idx   = slot_ext[IW-1:0];
              st_wdata = '0;
            end else begin
              mul_start = 1'b1;
            end
          end else if (in_cmd == CMD_START) begin
            res_nxt   = '0;
            e_nxt     = in_exp;
            pdone_nxt = 1'b0;
            i_nxt     = '0;
            j_nxt     = '0;
          end
        end
      end
      ST_LOAD_RUN: begin
        st_we = mul_done;
      end
      ST_INIT: begin
        if (last_i) begin
          // reduce the tap again by the current modulus
          mul_start = 1'b1;
          mul_b     = tap_r[nl - j_r];
        end else begin
          p_we = 1'b1;
          s_we = 1'b1;
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      ST_INIT_RUN: begin
        if (mul_done) begin
          p_we    = 1'b1;
          s_we    = 1'b1;
          s_wdata = mul_res;
          j_nxt   = last_j ? '0 : j_r + 1'b1;
        end
      end
      ST_CHECK: begin
        i_nxt   = '0;
        j_nxt   = '0;
        z_nxt   = '0;
        acc_nxt = '0;
        if (e_r == '0) begin
          sq_nxt = 1'b0;
        end else if (e_r[0] && !pdone_r) begin
          sq_nxt    = 1'b0;
          pdone_nxt = 1'b1;
        end else begin
          e_nxt     = e_shift;
          pdone_nxt = 1'b0;
          sq_nxt    = 1'b1;
        end
      end
      ST_MM_MUL: begin
        mul_start = 1'b1;
        mul_a     = sq_r ? sa_q : p_q;
        mul_b     = sb_q;
      end
      ST_MM_RUN: begin
        if (mul_done) begin
          if (last_z) begin
            t_we    = 1'b1;
            acc_nxt = '0;
            z_nxt   = '0;
            if (last_j) begin
              j_nxt = '0;
              i_nxt = last_i ? '0 : i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end else begin
            acc_nxt = acc_sum;
            z_nxt   = z_r + 1'b1;
          end
        end
      end
      ST_CP_WR: begin
        p_we    = ~sq_r;
        s_we    = sq_r;
        p_wdata = t_q;
        s_wdata = t_q;
        if (last_j) begin
          j_nxt = '0;
          i_nxt = last_i ? '0 : i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_FIN_MUL: begin
        mul_start = 1'b1;
        mul_a     = p_q;
        mul_b     = seed_r[j_r];
      end
      ST_FIN_RUN: begin
        if (mul_done) begin
          if (last_j) begin
            res_nxt = acc_sum;
          end else begin
            acc_nxt = acc_sum;
            j_nxt   = j_r + 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_term_nxt  = res_r;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      e_r         <= '0;
      pdone_r     <= 1'b0;
      for (int k = 0; k < MAX_ORDER; k++) begin
        tap_r[k]  <= '0;
        seed_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      e_r         <= e_nxt;
      pdone_r     <= pdone_nxt;
      if (st_we) begin
        if (st_seed) begin
          seed_r[st_idx] <= st_wdata;
        end else begin
          tap_r[st_idx] <= st_wdata;
        end
      end
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    z_r        <= z_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    sq_r       <= sq_nxt;
    seed_sel_r <= seed_sel_nxt;
    slot_r     <= slot_nxt;
    out_term_r <= out_term_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_term_r);

  // every modular product lands below the modulus
  `LRT_ASSERT_IMP(a_mul_reduced, mul_done, mul_res < modulus_r,
                  "multiplier result not reduced")
  // a start with a usable modulus enters the matrix setup
  `LRT_ASSERT_NXT(a_start_init, in_xfer && in_cmd == CMD_START && !small_mod,
                  state_r == ST_INIT, "start did not enter setup")
  // a finished term reaches the output register once it is free
  `LRT_ASSERT_NXT(a_out_load, state_r == ST_OUT && !out_busy,
                  out_tvalid && state_r == ST_IDLE, "result not presented")

endmodule
